FILE: rtl/brff_pkg.sv
// ----------------------------------------------------------------------------
// brff_pkg
// Shared types, sizes and operation codes of the range bit vector with
// find-first.
// ----------------------------------------------------------------------------
package brff_pkg;

	localparam int MAX_BITS    = 256;
	localparam int IDX_W       = $clog2(MAX_BITS);
	localparam int CNT_W       = IDX_W + 1;
	localparam int END_W       = IDX_W + 2;
	localparam int FUNC_W      = 3;
	localparam int CHUNK_W     = 32;
	localparam int NUM_CHUNKS  = MAX_BITS / CHUNK_W;
	localparam int CHUNK_SEL_W = $clog2(NUM_CHUNKS);
	localparam int OFF_W       = $clog2(CHUNK_W);

	typedef logic [FUNC_W-1:0]      func_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [END_W-1:0]       end_t;
	typedef logic [MAX_BITS-1:0]    vec_t;
	typedef logic [CHUNK_W-1:0]     chunk_t;
	typedef logic [CHUNK_SEL_W-1:0] chunk_sel_t;
	typedef logic [OFF_W-1:0]       off_t;

	localparam func_t OP_TEST       = 3'd0;
	localparam func_t OP_SET        = 3'd1;
	localparam func_t OP_CLEAR      = 3'd2;
	localparam func_t OP_FLIP       = 3'd3;
	localparam func_t OP_FIND_SET   = 3'd4;
	localparam func_t OP_FIND_CLEAR = 3'd5;

	localparam cnt_t ACTIVE_BITS_RESET = cnt_t'(MAX_BITS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MASK,
		ST_APPLY,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic build_mask;
		logic apply;
		logic scan_step;
		logic load_result;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic err;
		logic op_modify;
		logic op_scan;
		logic hit_now;
		logic last_chunk;
	} sts_t;

	// Position of the lowest set bit of a chunk; zero when none is set.
	function automatic off_t lowest_set(input chunk_t v);
		off_t pos;
		pos = '0;
		for (int i = CHUNK_W - 1; i >= 0; i--) begin
			if (v[i])
				pos = off_t'(i);
		end
		return pos;
	endfunction

endpackage

FILE: rtl/brff_cfg_if.sv
// ----------------------------------------------------------------------------
// brff_cfg_if
// Write channel of the active_bits configuration register.
// ----------------------------------------------------------------------------
interface brff_cfg_if;
	logic              valid;
	logic              ready;
	brff_pkg::cnt_t    active_bits;

	modport source(output valid, output active_bits, input ready);
	modport sink(input valid, input active_bits, output ready);
endinterface

FILE: rtl/brff_cmd_if.sv
// ----------------------------------------------------------------------------
// brff_cmd_if
// Command channel: operation, start position and range length.
// ----------------------------------------------------------------------------
interface brff_cmd_if;
	logic              valid;
	logic              ready;
	brff_pkg::func_t   func;
	brff_pkg::idx_t    start_position;
	brff_pkg::cnt_t    range_length;

	modport source(output valid, output func, output start_position,
		output range_length, input ready);
	modport sink(input valid, input func, input start_position,
		input range_length, output ready);
endinterface

FILE: rtl/brff_res_if.sv
// ----------------------------------------------------------------------------
// brff_res_if
// Result channel: one result per command.
// ----------------------------------------------------------------------------
interface brff_res_if;
	logic              valid;
	logic              ready;
	logic              all_set;
	logic              found;
	brff_pkg::idx_t    found_index;
	logic              range_error;

	modport source(output valid, output all_set, output found,
		output found_index, output range_error, input ready);
	modport sink(input valid, input all_set, input found,
		input found_index, input range_error, output ready);
endinterface

FILE: rtl/brff_ctrl.sv
// ----------------------------------------------------------------------------
// brff_ctrl
// Command sequencer: accepts a command, steps the datapath through mask
// build, update or chunk scan, and hands the result to the output register.
// ----------------------------------------------------------------------------
module brff_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	output logic           res_valid,
	input  logic           res_ready,
	output brff_pkg::ctl_t ctl,
	input  brff_pkg::sts_t sts
);
	import brff_pkg::*;

	state_t state_q, state_d;
	logic   res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		cmd_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					ctl.capture = 1'b1;
					state_d     = ST_MASK;
				end
			end
			ST_MASK: begin
				ctl.build_mask = 1'b1;
				if (sts.err)
					state_d = ST_DONE;
				else if (sts.op_modify)
					state_d = ST_APPLY;
				else if (sts.op_scan)
					state_d = ST_SCAN;
				else
					state_d = ST_DONE;
			end
			ST_APPLY: begin
				ctl.apply = 1'b1;
				state_d   = ST_DONE;
			end
			ST_SCAN: begin
				ctl.scan_step = 1'b1;
				if (sts.hit_now || sts.last_chunk)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				// The result waits here until the output register is free.
				if (!res_valid_q || res_ready) begin
					ctl.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.load_result) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
endmodule

FILE: rtl/brff_dp.sv
// ----------------------------------------------------------------------------
// brff_dp
// Datapath: bit store, active size register, range mask, chunked
// find-first scan and the result register.
// ----------------------------------------------------------------------------
module brff_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  brff_pkg::cnt_t    cfg_active_bits,
	input  brff_pkg::func_t   cmd_func,
	input  brff_pkg::idx_t    cmd_start,
	input  brff_pkg::cnt_t    cmd_length,
	input  brff_pkg::ctl_t    ctl,
	output brff_pkg::sts_t    sts,
	output logic              res_all_set,
	output logic              res_found,
	output brff_pkg::idx_t    res_found_index,
	output logic              res_range_error
);
	import brff_pkg::*;

	vec_t       store_q;
	cnt_t       active_bits_q;
	func_t      op_q;
	idx_t       start_q;
	end_t       end_q;
	logic       err_q;
	vec_t       mask_q;
	chunk_sel_t chunk_q;
	logic       found_q;
	idx_t       index_q;
	logic       all_set_q;
	logic       hit_q;
	idx_t       hit_index_q;
	logic       error_q;

	end_t       size_in_use;
	end_t       cmd_end;
	chunk_t     cur_data;
	chunk_t     cur_mask;
	chunk_t     cur_match;
	logic       want_set;
	logic       is_find;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_bits_q <= ACTIVE_BITS_RESET;
		end else if (cfg_we) begin
			active_bits_q <= cfg_active_bits;
		end
	end

	always_comb begin
		if (end_t'(active_bits_q) > end_t'(MAX_BITS))
			size_in_use = end_t'(MAX_BITS);
		else
			size_in_use = end_t'(active_bits_q);
		cmd_end = end_t'(cmd_start) + end_t'(cmd_length);
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			op_q    <= cmd_func;
			start_q <= cmd_start;
			end_q   <= cmd_end;
			err_q   <= (cmd_end > size_in_use);
		end
		if (ctl.build_mask) begin
			for (int i = 0; i < MAX_BITS; i++)
				mask_q[i] <= (end_t'(i) >= end_t'(start_q)) && (end_t'(i) < end_q);
		end
	end

	assign want_set = (op_q == OP_FIND_SET);
	assign is_find  = (op_q == OP_FIND_SET) || (op_q == OP_FIND_CLEAR);

	// The test operation scans for a clear bit; finding none means all set.
	assign cur_data  = store_q[{chunk_q, off_t'(0)} +: CHUNK_W];
	assign cur_mask  = mask_q[{chunk_q, off_t'(0)} +: CHUNK_W];
	assign cur_match = (want_set ? cur_data : ~cur_data) & cur_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
		end else if (ctl.apply) begin
			case (op_q)
				OP_SET:   store_q <= store_q | mask_q;
				OP_CLEAR: store_q <= store_q & ~mask_q;
				OP_FLIP:  store_q <= store_q ^ mask_q;
				default:  store_q <= store_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			chunk_q <= '0;
			found_q <= 1'b0;
			index_q <= '0;
		end else if (ctl.scan_step) begin
			chunk_q <= chunk_q + chunk_sel_t'(1);
			if (|cur_match) begin
				found_q <= 1'b1;
				index_q <= {chunk_q, lowest_set(cur_match)};
			end
		end
	end

	always_comb begin
		sts.err        = err_q;
		sts.op_modify  = (op_q == OP_SET) || (op_q == OP_CLEAR) || (op_q == OP_FLIP);
		sts.op_scan    = (op_q == OP_TEST) || is_find;
		sts.hit_now    = |cur_match;
		sts.last_chunk = (chunk_q == chunk_sel_t'(NUM_CHUNKS - 1));
	end

	always_ff @(posedge clk) begin
		if (ctl.load_result) begin
			all_set_q   <= !err_q && (op_q == OP_TEST) && !found_q;
			hit_q       <= !err_q && is_find && found_q;
			hit_index_q <= (!err_q && is_find && found_q) ? index_q : '0;
			error_q     <= err_q;
		end
	end

	assign res_all_set     = all_set_q;
	assign res_found       = hit_q;
	assign res_found_index = hit_index_q;
	assign res_range_error = error_q;
endmodule

FILE: rtl/bitmap_range_ops_find_first.sv
// ----------------------------------------------------------------------------
// bitmap_range_ops_find_first
// Bit vector with range test, set, clear, flip and find-first operations.
// ----------------------------------------------------------------------------
// The cfg channel writes active_bits, the number of bits in use; write it only
// while no command is in flight. Each transfer on cmd carries an operation,
// a start position and a length, and yields exactly one transfer on res.
// A range that ends past the size in use reports range_error and changes
// nothing. One command is handled at a time: it is taken in the idle cycle,
// its range mask is built in the next cycle, and then the store is updated
// or scanned 32 bits per cycle, stopping at the first match or after the
// last chunk. The result then waits in the done state until the output
// register is free. The output register holds a result until res is ready;
// meanwhile the next command is accepted and worked on, and waits before the
// output if the receiver still stalls. Reset clears every bit of the store,
// sets active_bits to 256 and empties the output register.
// ----------------------------------------------------------------------------
module bitmap_range_ops_find_first (
	input  logic   clk,
	input  logic   arst_n,
	brff_cfg_if.sink   cfg,
	brff_cmd_if.sink   cmd,
	brff_res_if.source res
);
	import brff_pkg::*;

	ctl_t ctl;
	sts_t sts;

	assign cfg.ready = 1'b1;

	brff_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.ctl       (ctl),
		.sts       (sts)
	);

	brff_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg.valid),
		.cfg_active_bits (cfg.active_bits),
		.cmd_func        (cmd.func),
		.cmd_start       (cmd.start_position),
		.cmd_length      (cmd.range_length),
		.ctl             (ctl),
		.sts             (sts),
		.res_all_set     (res.all_set),
		.res_found       (res.found),
		.res_found_index (res.found_index),
		.res_range_error (res.range_error)
	);
endmodule

FILE: tb/tb_bitmap_range_ops_find_first.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_range_ops_find_first
// Self-checking bench for the range bit vector with find-first. Commands go
// in through the command channel and the bench keeps its own copy of the
// bit store and of active_bits. Every result that comes back is compared
// field by field with the oldest outstanding prediction. The run steps
// through several active_bits settings, the extremes among them, and mixes
// of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_bitmap_range_ops_find_first;
	import brff_pkg::*;

	localparam func_t OP_RESERVED_LO = 3'd6;
	localparam func_t OP_RESERVED_HI = 3'd7;
	localparam int    PHASES         = 9;
	localparam int    RANDOM_PER_PHASE = 62;
	localparam int    STUCK_LIMIT    = 4000;
	localparam int    SETTLE_CYCLES  = 16;
	localparam int    MAX_REPORTS    = 40;

	typedef struct packed {
		logic all_set;
		logic found;
		idx_t found_index;
		logic range_error;
	} outcome_t;

	class range_scoreboard;
		vec_t        bits;
		cnt_t        active_bits;
		outcome_t    pending[$];
		int unsigned mismatches;
		int unsigned compared;
		int unsigned commands;
		int unsigned range_errors;
		int unsigned find_hits;

		function new();
			bits = '0;
			active_bits = ACTIVE_BITS_RESET;
			mismatches = 0;
			compared = 0;
			commands = 0;
			range_errors = 0;
			find_hits = 0;
		endfunction

		function int unsigned size_in_use();
			return (active_bits > MAX_BITS) ? MAX_BITS : active_bits;
		endfunction

		// Applies an accepted command to the local store and queues its outcome.
		function void note_command(func_t f, idx_t s, cnt_t n);
			outcome_t    o;
			int unsigned last;
			logic        want;
			o = '0;
			last = s + n;
			want = (f == OP_FIND_SET);
			commands++;
			if (last > size_in_use()) begin
				o.range_error = 1'b1;
				range_errors++;
			end else begin
				case (f)
					OP_TEST: begin
						o.all_set = 1'b1;
						for (int unsigned i = s; i < last; i++) begin
							if (!bits[i]) begin
								o.all_set = 1'b0;
								break;
							end
						end
					end
					OP_SET: for (int unsigned i = s; i < last; i++) bits[i] = 1'b1;
					OP_CLEAR: for (int unsigned i = s; i < last; i++) bits[i] = 1'b0;
					OP_FLIP: for (int unsigned i = s; i < last; i++) bits[i] = ~bits[i];
					OP_FIND_SET, OP_FIND_CLEAR: begin
						for (int unsigned i = s; i < last; i++) begin
							if (bits[i] == want) begin
								o.found = 1'b1;
								o.found_index = idx_t'(i);
								find_hits++;
								break;
							end
						end
					end
					default: ;
				endcase
			end
			pending.push_back(o);
		endfunction

		task report_mismatch(string msg);
			if (mismatches < MAX_REPORTS)
				$display("mismatch at %0t: %s", $time, msg);
			mismatches++;
		endtask

		task check_result(logic a, logic f, idx_t idx, logic e);
			outcome_t want;
			compared++;
			if (pending.size() == 0) begin
				report_mismatch("result transfer with no command outstanding");
				return;
			end
			want = pending.pop_front();
			if (a !== want.all_set)
				report_mismatch($sformatf("all_set %b, expected %b", a, want.all_set));
			if (f !== want.found)
				report_mismatch($sformatf("found %b, expected %b", f, want.found));
			if (idx !== want.found_index)
				report_mismatch($sformatf("found_index %0d, expected %0d", idx,
					want.found_index));
			if (e !== want.range_error)
				report_mismatch($sformatf("range_error %b, expected %b", e,
					want.range_error));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned send_idle = 0;
	int unsigned recv_stall = 0;

	cnt_t        phase_bits[PHASES] = '{256, 1, 8, 100, 0, 511, 255, 37, 256};
	int unsigned phase_send[PHASES] = '{0, 85, 0, 25, 0, 85, 0, 25, 0};
	int unsigned phase_stall[PHASES] = '{0, 0, 85, 25, 0, 0, 85, 25, 0};

	range_scoreboard sb = new();

	brff_cfg_if cfg_bus ();
	brff_cmd_if cmd_bus ();
	brff_res_if res_bus ();

	bitmap_range_ops_find_first dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.cmd    (cmd_bus),
		.res    (res_bus)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic write_active_bits(cnt_t v);
		cfg_bus.valid <= 1'b1;
		cfg_bus.active_bits <= v;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		sb.active_bits = v;
	endtask

	// Leaves valid high after the transfer so back-to-back commands need no gap.
	task automatic send_command(func_t f, idx_t s, cnt_t n);
		while ($urandom_range(99) < send_idle) begin
			cmd_bus.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.func <= f;
		cmd_bus.start_position <= s;
		cmd_bus.range_length <= n;
		do @(posedge clk); while (!cmd_bus.ready);
		sb.note_command(f, s, n);
	endtask

	// Mostly ranges that fit, so the store fills up and the finds have work;
	// the rest are overruns and fully random fields.
	task automatic send_random_command();
		int unsigned lim;
		int unsigned kind;
		int unsigned sv;
		int unsigned nv;
		int unsigned room;
		int unsigned n_min;
		func_t       f;
		lim = sb.size_in_use();
		kind = $urandom_range(99);
		if ($urandom_range(9) == 0)
			f = func_t'($urandom_range(OP_RESERVED_HI));
		else
			f = func_t'($urandom_range(OP_FIND_CLEAR));
		if (kind < 80) begin
			sv = $urandom_range((lim > 255) ? 255 : lim);
			room = lim - sv;
			if ($urandom_range(1))
				nv = $urandom_range((room < 40) ? room : 40);
			else
				nv = $urandom_range(room);
		end else if (kind < 95) begin
			sv = $urandom_range(255);
			n_min = (sv > lim) ? 0 : lim - sv + 1;
			if (sv > lim && $urandom_range(4) == 0)
				nv = 0;
			else
				nv = $urandom_range(511, n_min);
		end else begin
			f = func_t'($urandom_range(OP_RESERVED_HI));
			sv = $urandom_range(255);
			nv = $urandom_range(511);
		end
		send_command(f, idx_t'(sv), cnt_t'(nv));
	endtask

	task automatic send_directed();
		send_command(OP_TEST, 0, 256);
		send_command(OP_FIND_CLEAR, 0, 256);
		send_command(OP_FIND_SET, 0, 256);
		send_command(OP_TEST, 10, 0);
		send_command(OP_FIND_SET, 10, 0);
		send_command(OP_SET, 0, 256);
		send_command(OP_TEST, 0, 256);
		send_command(OP_FIND_CLEAR, 0, 256);
		send_command(OP_CLEAR, 255, 1);
		send_command(OP_FIND_CLEAR, 0, 256);
		send_command(OP_FLIP, 0, 256);
		send_command(OP_FIND_SET, 0, 256);
		send_command(OP_TEST, 255, 1);
		send_command(OP_SET, 31, 2);
		send_command(OP_FIND_SET, 0, 255);
		send_command(OP_FIND_SET, 33, 222);
		send_command(OP_TEST, 255, 2);
		send_command(OP_SET, 0, 511);
		send_command(OP_FLIP, 255, 0);
		send_command(OP_RESERVED_LO, 0, 4);
		send_command(OP_RESERVED_HI, 200, 100);
		send_command(OP_CLEAR, 0, 256);
		send_command(OP_FIND_CLEAR, 100, 50);
		send_command(OP_FIND_SET, 0, 1);
	endtask

	always @(posedge clk) begin
		if (res_bus.valid && res_bus.ready)
			sb.check_result(res_bus.all_set, res_bus.found, res_bus.found_index,
				res_bus.range_error);
		res_bus.ready <= ($urandom_range(99) >= recv_stall);
	end

	// Ends the run when no transfer of any kind happens for too long.
	initial begin : watchdog
		int unsigned stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready) ||
					(cfg_bus.valid && cfg_bus.ready))
				stuck = 0;
			else
				stuck++;
		end
		$display("watchdog: no transfer for %0d cycles", STUCK_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.active_bits = ACTIVE_BITS_RESET;
		cmd_bus.valid = 1'b0;
		cmd_bus.func = OP_TEST;
		cmd_bus.start_position = '0;
		cmd_bus.range_length = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < PHASES; p++) begin
			send_idle = phase_send[p];
			recv_stall = phase_stall[p];
			write_active_bits(phase_bits[p]);
			if (p == 0)
				send_directed();
			for (int k = 0; k < RANDOM_PER_PHASE; k++)
				send_random_command();
			cmd_bus.valid <= 1'b0;
			// The register may only change once every result has come back.
			while (sb.pending.size() != 0)
				@(posedge clk);
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Ran %0d commands across %0d active_bits settings and four flow-control mixes.",
			sb.commands, PHASES);
		$display("Compared %0d results: %0d range errors, %0d successful finds.",
			sb.compared, sb.range_errors, sb.find_hits);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: sim.f
rtl/brff_pkg.sv
rtl/brff_cfg_if.sv
rtl/brff_cmd_if.sv
rtl/brff_res_if.sv
rtl/brff_ctrl.sv
rtl/brff_dp.sv
rtl/bitmap_range_ops_find_first.sv
tb/tb_bitmap_range_ops_find_first.sv
